>>> design/hhpd_pkg.sv
// ----------------------------------------------------------------------------
// hhpd_pkg
// shared types, constants and the controller command bundle of the
// haptic heading pulse driver
// ----------------------------------------------------------------------------
package hhpd_pkg;

   // item widths on the stream ports (fields packed low first, padded to bytes)
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // pulse timing
   localparam logic [9:0] MIN_PULSE     = 10'd150;
   localparam logic [9:0] REACHED_PULSE = 10'd75;
   localparam logic [9:0] MAX_PULSE_MS  = 10'd1000;
   localparam logic [1:0] BURSTS        = 2'd2;

   // heading geometry in hundredths of a degree
   localparam logic [15:0] QUARTER   = 16'd9000;
   localparam logic [15:0] HALF_TURN = 16'd18000;
   localparam logic [15:0] FULL_TURN = 16'd36000;
   localparam logic [15:0] MOTOR_ANGLE [4] = '{16'd0, 16'd9000, 16'd18000, 16'd27000};

   localparam logic [7:0] FULL_DUTY = 8'hff;

   // floor(255*x/9000) = floor(17*x/600) = (x * 17*ceil(2^28/600)) >> 28, exact for x <= 9000
   localparam int          DUTY_SHIFT = 28;
   localparam logic [22:0] DUTY_RECIP = 23'd7605681;

   // pulse quotient never needs more than 10 bits before the clamp to 1000
   localparam int         DIV_BITS  = 10;
   localparam logic [3:0] DIV_LAST  = 4'(DIV_BITS - 1);
   localparam logic [3:0] DUTY_LAST = 4'd4;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_CMD  = 2'd1,
      REQ_STOP = 2'd2,
      REQ_NOP  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_OFF  = 2'd2,
      PH_CONT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CSR_MAX_PULSE = 2'd0,
      CSR_MAX_DIST  = 2'd1,
      CSR_RADIUS    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_DIV,
      ST_DUTY,
      ST_COMMIT,
      ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic       capture;
      logic       apply_tick;
      logic       apply_stop;
      logic       mul;
      logic       sat;
      logic       div_step;
      logic       duty_x;
      logic [1:0] duty_x_idx;
      logic       duty_wr;
      logic [1:0] duty_wr_idx;
      logic       commit;
      logic       out_load;
   } ctl_cmd_type;

endpackage

>>> design/hhpd_ctrl.sv
// ----------------------------------------------------------------------------
// hhpd_ctrl
// sequencer: takes one item at a time, steps the divider and the duty unit,
// and owns the result valid flag
// ----------------------------------------------------------------------------
module hhpd_ctrl import hhpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          out_free;
   req_kind_type  kind;

   assign kind       = req_kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (kind == REQ_CMD) ? ST_MUL : ST_EMIT;
            end
         end
         ST_MUL:    state_in = ST_SAT;
         ST_SAT:    state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == DIV_LAST) state_in = ST_DUTY;
         end
         ST_DUTY: begin
            if (cnt_ff == DUTY_LAST) state_in = ST_COMMIT;
         end
         ST_COMMIT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // step counter shared by divide and duty passes
   always_comb begin
      cnt_in = 4'd0;
      if ((state_ff == ST_DIV && cnt_ff != DIV_LAST) ||
          (state_ff == ST_DUTY && cnt_ff != DUTY_LAST)) begin
         cnt_in = cnt_ff + 4'd1;
      end
   end

   // outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture    = (kind == REQ_CMD);
               cmd.apply_tick = (kind == REQ_TICK);
               cmd.apply_stop = (kind == REQ_STOP);
            end
         end
         ST_MUL:    cmd.mul = 1'b1;
         ST_SAT:    cmd.sat = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_DUTY: begin
            cmd.duty_x      = (cnt_ff != DUTY_LAST);
            cmd.duty_x_idx  = cnt_ff[1:0];
            cmd.duty_wr     = (cnt_ff != 4'd0);
            cmd.duty_wr_idx = 2'(cnt_ff - 4'd1);
         end
         ST_COMMIT: cmd.commit = 1'b1;
         ST_EMIT:   cmd.out_load = out_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/hhpd_dpath.sv
// ----------------------------------------------------------------------------
// hhpd_dpath
// datapath: config registers, pulse length divider, duty multiplier,
// pulse phase state and the result register
// ----------------------------------------------------------------------------
module hhpd_dpath import hhpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // configuration
   logic [15:0] mpd_ff, mgd_ff, tr_ff;

   // captured command
   logic [15:0] head_ff, dist_ff;
   logic        en_ff, test_ff;

   // pulse length divider
   logic [31:0] prod_ff;
   logic        ok_ff, sat_ff;
   logic [25:0] rem_ff;
   logic [24:0] dsh_ff;
   logic [DIV_BITS-1:0] quo_ff;

   // duty unit
   logic [13:0] x_ff;
   logic [36:0] duty_prod;
   logic [7:0]  duty_val;

   // pattern state
   logic [7:0]  pattern_ff [4];
   logic [7:0]  pattern_in [4];
   logic [7:0]  driven_ff [4];
   logic [7:0]  driven_in [4];
   phase_type   phase_ff, phase_in;
   logic [1:0]  bursts_ff, bursts_in;
   logic [9:0]  ms_ff, ms_in;
   logic [9:0]  plen_ff, plen_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [15:0] diff_d, diff_p, den;
   logic        rem_ge;
   logic [10:0] pulse_sum;
   logic [9:0]  pulse_calc, plen_new;
   logic [9:0]  ms_dec;

   function automatic logic [13:0] motor_x(input logic [15:0] h, input logic [1:0] idx);
      logic [15:0] ang;
      logic [15:0] d;
      begin
         ang = MOTOR_ANGLE[idx];
         d   = (h >= ang) ? h - ang : ang - h;
         if (d > HALF_TURN) d = FULL_TURN - d;
         if (h >= FULL_TURN || d >= QUARTER) begin
            motor_x = 14'd0;
         end else begin
            motor_x = 14'(QUARTER - d);
         end
      end
   endfunction

   assign diff_d = dist_ff - tr_ff;
   assign diff_p = mpd_ff - 16'(MIN_PULSE);
   assign den    = mgd_ff - tr_ff;
   assign rem_ge = (rem_ff >= {1'b0, dsh_ff});

   assign duty_prod = 37'(x_ff) * 37'(DUTY_RECIP);
   assign duty_val  = duty_prod[DUTY_SHIFT +: 8];

   always_comb begin
      pulse_sum = 11'(MIN_PULSE) + 11'(quo_ff);
      if (!ok_ff) begin
         pulse_calc = MIN_PULSE;
      end else if (sat_ff || pulse_sum > 11'(MAX_PULSE_MS)) begin
         pulse_calc = MAX_PULSE_MS;
      end else begin
         pulse_calc = pulse_sum[9:0];
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mpd_ff <= 16'd1000;
         mgd_ff <= 16'd1000;
         tr_ff  <= 16'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_PULSE: mpd_ff <= csr_wdata;
            CSR_MAX_DIST:  mgd_ff <= csr_wdata;
            CSR_RADIUS:    tr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // command arithmetic
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         head_ff <= req_tdata[15:0];
         en_ff   <= req_tdata[16];
         test_ff <= req_tdata[17];
         dist_ff <= req_tdata[33:18];
      end
      if (cmd.mul) begin
         prod_ff <= {16'd0, diff_d} * {16'd0, diff_p};
         ok_ff   <= (mpd_ff > 16'(MIN_PULSE)) && (dist_ff >= tr_ff) && (mgd_ff > tr_ff);
      end
      if (cmd.sat) begin
         sat_ff <= (prod_ff >= {6'd0, den, 10'd0});
         rem_ff <= prod_ff[25:0];
         dsh_ff <= {den, 9'd0};
      end
      if (cmd.div_step) begin
         if (rem_ge) rem_ff <= rem_ff - {1'b0, dsh_ff};
         quo_ff <= {quo_ff[DIV_BITS-2:0], rem_ge};
         dsh_ff <= {1'b0, dsh_ff[24:1]};
      end
      if (cmd.duty_x) begin
         x_ff <= motor_x(head_ff, cmd.duty_x_idx);
      end
   end

   // pattern and phase state
   always_comb begin
      pattern_in = pattern_ff;
      driven_in  = driven_ff;
      phase_in   = phase_ff;
      bursts_in  = bursts_ff;
      ms_in      = ms_ff;
      plen_in    = plen_ff;
      ms_dec     = (ms_ff != 10'd0) ? ms_ff - 10'd1 : 10'd0;
      plen_new   = 10'd0;

      if (cmd.duty_wr) begin
         pattern_in[cmd.duty_wr_idx] = en_ff ? duty_val : (test_ff ? FULL_DUTY : 8'd0);
      end

      if (cmd.commit) begin
         if (dist_ff < tr_ff) begin
            for (int i = 0; i < 4; i++) pattern_in[i] = FULL_DUTY;
            plen_new = REACHED_PULSE;
         end else if (dist_ff < mgd_ff) begin
            plen_new = pulse_calc;
         end else begin
            plen_new = 10'd0;
         end
         plen_in   = plen_new;
         driven_in = pattern_in;
         if (plen_new == 10'd0) begin
            phase_in = PH_CONT;
         end else begin
            phase_in  = PH_ON;
            bursts_in = BURSTS;
            ms_in     = plen_new;
         end
      end

      if (cmd.apply_tick && (phase_ff == PH_ON || phase_ff == PH_OFF)) begin
         ms_in = ms_dec;
         if (ms_dec == 10'd0) begin
            if (phase_ff == PH_ON) begin
               for (int i = 0; i < 4; i++) driven_in[i] = 8'd0;
               bursts_in = (bursts_ff != 2'd0) ? bursts_ff - 2'd1 : 2'd0;
               phase_in  = PH_OFF;
               ms_in     = plen_ff;
            end else if (bursts_ff != 2'd0) begin
               driven_in = pattern_ff;
               phase_in  = PH_ON;
               ms_in     = plen_ff;
            end else begin
               phase_in  = PH_IDLE;
            end
         end
      end

      if (cmd.apply_stop) begin
         phase_in = PH_IDLE;
         for (int i = 0; i < 4; i++) driven_in[i] = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pattern_ff[i] <= 8'd0;
            driven_ff[i]  <= 8'd0;
         end
         phase_ff  <= PH_IDLE;
         bursts_ff <= 2'd0;
         ms_ff     <= 10'd0;
         plen_ff   <= 10'd0;
      end else begin
         pattern_ff <= pattern_in;
         driven_ff  <= driven_in;
         phase_ff   <= phase_in;
         bursts_ff  <= bursts_in;
         ms_ff      <= ms_in;
         plen_ff    <= plen_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {6'd0, phase_ff, driven_ff[3], driven_ff[2], driven_ff[1],
                         driven_ff[0]};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

>>> design/haptic_heading_pulse_driver_unit.sv
// ----------------------------------------------------------------------------
// haptic_heading_pulse_driver_unit
// four-motor haptic heading driver: guidance commands, 1 ms ticks and stop
// ----------------------------------------------------------------------------
// order: tick, stop and ignored items go straight to the result register;
//   a guidance command first passes multiply, saturate, the 10-step serial
//   pulse length divider, the shared duty multiplier that visits the four
//   motors in turn, and commit; one item is in work at a time, and the next
//   is taken once the result is loaded, which a stalled result port holds off
// reset: synchronous, active high; duties zero, phase idle, config at defaults
// ----------------------------------------------------------------------------
module haptic_heading_pulse_driver_unit import hhpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] heading_centideg, [16] guidance_enable, [17] test_all_on,
   // [33:18] target_distance, [39:34] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]            req_tuser,
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] front_duty, [15:8] right_duty, [23:16] rear_duty, [31:24] left_duty,
   // [33:32] phase, [39:34] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // register writes
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   // command bundle from the sequencer to the datapath
   ctl_cmd_type cmd;

   // sequencer: one item in flight, result held in a register so the next
   // item can be taken while the result waits
   hhpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // datapath: config, divider, duty unit, phase timer, result register
   hhpd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> design/hhpd_checker.sv
// ----------------------------------------------------------------------------
// hhpd_checker
// port-level checks of the haptic heading pulse driver
// ----------------------------------------------------------------------------
module hhpd_checker import hhpd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // idle and pulse-off phases never drive a motor
   a_quiet_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[33:32] == PH_IDLE || rsp_tdata[33:32] == PH_OFF)
      |-> rsp_tdata[31:0] == 32'd0)
      else $error("motor driven in idle or off phase");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while another is in work");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind haptic_heading_pulse_driver_unit hhpd_checker u_hhpd_checker (.*);
